### rtl/core/vnth_pkg.sv
// ----------------------------------------------------------------------------
// vnth_pkg
// Shared widths and constants of the value noise terrain height core.
// ----------------------------------------------------------------------------
package vnth_pkg;

   localparam int COORD_BITS  = 16;
   localparam int CELL_LOG2   = 4;
   localparam int LAT_BITS    = COORD_BITS - CELL_LOG2;
   localparam int HEIGHT_BITS = 16;
   localparam int NOISE_BITS  = 44;
   localparam int SMOOTH_BITS = 36;
   localparam int INTERP_BITS = 40;
   localparam int SCALED_BITS = 48;
   localparam int BLEND_SHIFT = 34 + 2 * CELL_LOG2;
   localparam int NUM_STAGES  = 8;
   localparam int HASH_STAGES = 4;

   localparam logic [31:0] HASH_ROW_MUL = 32'd57;
   localparam logic [31:0] HASH_SQ_MUL  = 32'd15731;
   localparam logic [31:0] HASH_SQ_ADD  = 32'd789221;
   localparam logic [31:0] HASH_OFFSET  = 32'd1376312589;
   localparam logic [30:0] HASH_MASK    = 31'h7fff_ffff;
   localparam logic [31:0] LATTICE_ONE  = 32'h4000_0000;

   localparam logic [HEIGHT_BITS-1:0] LIMIT_RESET = 16'd62;

   typedef logic signed [31:0] lattice_type;

endpackage

### rtl/core/vnth_hash.sv
// ----------------------------------------------------------------------------
// vnth_hash
// Four-stage integer hash of one lattice point into a Q1.30 noise value.
// ----------------------------------------------------------------------------
module vnth_hash (
   input  logic                    clock,
   input  logic [vnth_pkg::HASH_STAGES-1:0] stage_en,
   input  logic [31:0]             lat_x,
   input  logic [31:0]             lat_z,
   output vnth_pkg::lattice_type   value
);

   logic [31:0] n1_ff, n1_in;
   logic [31:0] n2_ff, sq_ff;
   logic [31:0] n3_ff, poly_ff;
   vnth_pkg::lattice_type value_ff;
   logic [31:0] mix;
   logic [31:0] prod;

   // combine coordinates and scramble
   always_comb begin
      mix   = lat_x + lat_z * vnth_pkg::HASH_ROW_MUL;
      n1_in = (mix << 13) ^ mix;
   end

   assign prod = n3_ff * poly_ff + vnth_pkg::HASH_OFFSET;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         n1_ff <= n1_in;
      end
      if (stage_en[1]) begin
         n2_ff <= n1_ff;
         sq_ff <= n1_ff * n1_ff;
      end
      if (stage_en[2]) begin
         n3_ff   <= n2_ff;
         poly_ff <= sq_ff * vnth_pkg::HASH_SQ_MUL + vnth_pkg::HASH_SQ_ADD;
      end
      if (stage_en[3]) begin
         value_ff <= $signed(vnth_pkg::LATTICE_ONE)
                   - $signed({1'b0, prod[30:0] & vnth_pkg::HASH_MASK});
      end
   end

   assign value = value_ff;

endmodule

### rtl/core/value_noise_terrain_height_core.sv
// ----------------------------------------------------------------------------
// value_noise_terrain_height_core
// Smoothed 2D value noise terrain height, one column per cycle unless rsp_ready stalls the pipe.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a column coordinate (req_coord_x, req_coord_z);
//   rsp channel returns the clamped height and the blended noise value
//   scaled by 2^42, one rsp beat per req beat, in order.
//   csr_write_en / csr_write_data set the upper height clamp (reset 62);
//   write it only while no beat is in flight.
// Pipeline: a req beat reaches rsp_valid through four hash stages, smoothing,
//   x blend, z blend, height and clamp.
// Throughput: one beat per cycle while rsp_ready does not stall; the 16 lattice
//   hashes of the 4x4 neighbourhood run in 16 parallel lanes, so nothing is shared.
// Stall: each stage holds while the next one is full and stalled, so
//   bubbles collapse and req_ready only drops when the whole pipe is full.
// Reset: synchronous, clears all stage valid bits and sets the clamp
//   register to 62.
// ----------------------------------------------------------------------------
module value_noise_terrain_height_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_coord_x,
   input  logic [15:0] req_coord_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_height,
   output logic signed [43:0] rsp_noise_value,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   localparam int NS = vnth_pkg::NUM_STAGES;
   localparam int CL = vnth_pkg::CELL_LOG2;
   localparam int SMOOTH_BITS = vnth_pkg::SMOOTH_BITS;

   logic [NS-1:0] vld_ff, en;
   logic [vnth_pkg::HEIGHT_BITS-1:0] limit_ff;
   logic [CL-1:0] fx_ff [NS-3], fz_ff [NS-2];
   logic [vnth_pkg::LAT_BITS-1:0] lx, lz;
   logic [31:0] ax [4], az [4];
   vnth_pkg::lattice_type g [4][4];
   logic signed [vnth_pkg::SMOOTH_BITS-1:0] sm_in [4], sm_ff [4];
   logic signed [vnth_pkg::INTERP_BITS-1:0] ix_ff [2];
   logic signed [vnth_pkg::NOISE_BITS:0] blend_ff;
   logic signed [vnth_pkg::SCALED_BITS-1:0] scaled;
   logic [vnth_pkg::HEIGHT_BITS-1:0] h_raw, h_low, height_ff;
   logic signed [vnth_pkg::NOISE_BITS-1:0] noise_ff;
   logic signed [CL+1:0] wx0, wx1, wz0, wz1;

   // stage enables: a stage moves when empty or when its successor moves
   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         limit_ff <= vnth_pkg::LIMIT_RESET;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // lattice coordinates of the 4x4 neighbourhood, 32-bit wrapping
   always_comb begin
      lx = req_coord_x[vnth_pkg::COORD_BITS-1:CL];
      lz = req_coord_z[vnth_pkg::COORD_BITS-1:CL];
      for (int k = 0; k < 4; k++) begin
         ax[k] = {{(32 - vnth_pkg::LAT_BITS){1'b0}}, lx} + 32'(k) - 32'd1;
         az[k] = {{(32 - vnth_pkg::LAT_BITS){1'b0}}, lz} + 32'(k) - 32'd1;
      end
   end

   // sixteen hash lanes
   for (genvar j = 0; j < 4; j++) begin : g_row
      for (genvar i = 0; i < 4; i++) begin : g_col
         vnth_hash u_hash (
            .clock    (clock),
            .stage_en (en[vnth_pkg::HASH_STAGES-1:0]),
            .lat_x    (ax[i]),
            .lat_z    (az[j]),
            .value    (g[j][i])
         );
      end
   end

   // 3x3 smoothing around the four cell corners
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         int a, b;
         a = 1 + (k % 2);
         b = 1 + (k / 2);
         sm_in[k] = SMOOTH_BITS'(g[b-1][a-1]) + SMOOTH_BITS'(g[b-1][a+1])
                  + SMOOTH_BITS'(g[b+1][a-1]) + SMOOTH_BITS'(g[b+1][a+1])
                  + ((SMOOTH_BITS'(g[b][a-1]) + SMOOTH_BITS'(g[b][a+1])
                    + SMOOTH_BITS'(g[b-1][a]) + SMOOTH_BITS'(g[b+1][a])) <<< 1)
                  + (SMOOTH_BITS'(g[b][a]) <<< 2);
      end
   end

   // blend weights
   always_comb begin
      wx1 = $signed({2'b00, fx_ff[NS-4]});
      wx0 = $signed((CL+2)'(1 << CL)) - wx1;
      wz1 = $signed({2'b00, fz_ff[NS-3]});
      wz0 = $signed((CL+2)'(1 << CL)) - wz1;
   end

   // height: truncate toward zero, clamp low then high
   always_comb begin
      scaled = ($signed(vnth_pkg::SCALED_BITS'(8)) <<< vnth_pkg::BLEND_SHIFT)
             + vnth_pkg::SCALED_BITS'(blend_ff) * $signed(vnth_pkg::SCALED_BITS'(10));
      h_raw  = scaled[vnth_pkg::SCALED_BITS-1] ? 16'd1
             : 16'(scaled[vnth_pkg::SCALED_BITS-1:vnth_pkg::BLEND_SHIFT]);
      h_low  = (h_raw < 16'd1) ? 16'd1 : h_raw;
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (en[0]) begin
         fx_ff[0] <= req_coord_x[CL-1:0];
         fz_ff[0] <= req_coord_z[CL-1:0];
      end
      for (int i = 1; i < NS - 3; i++) begin
         if (en[i]) begin
            fx_ff[i] <= fx_ff[i-1];
         end
      end
      for (int i = 1; i < NS - 2; i++) begin
         if (en[i]) begin
            fz_ff[i] <= fz_ff[i-1];
         end
      end
      if (en[4]) begin
         sm_ff <= sm_in;
      end
      if (en[5]) begin
         ix_ff[0] <= sm_ff[0] * wx0 + sm_ff[1] * wx1;
         ix_ff[1] <= sm_ff[2] * wx0 + sm_ff[3] * wx1;
      end
      if (en[6]) begin
         blend_ff <= ix_ff[0] * wz0 + ix_ff[1] * wz1;
      end
      if (en[7]) begin
         height_ff <= (h_low > limit_ff) ? limit_ff : h_low;
         noise_ff  <= blend_ff[vnth_pkg::NOISE_BITS-1:0];
      end
   end

   assign rsp_valid       = vld_ff[NS-1];
   assign rsp_height      = height_ff;
   assign rsp_noise_value = noise_ff;

endmodule

### rtl/core/vnth_checker.sv
// ----------------------------------------------------------------------------
// vnth_checker
// Port-level checks of the value noise terrain height core.
// ----------------------------------------------------------------------------
module vnth_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_height,
   input logic [43:0] rsp_noise_value
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height)
         && $stable(rsp_noise_value))
      else $error("stalled rsp beat changed");

   // height cannot exceed 8 + 10
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_height <= 16'd18)
      else $error("height above noise range");

   // noise stays within plus or minus 2^42
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value[43] == rsp_noise_value[42])
         || (rsp_noise_value[41:0] == 42'd0))
      else $error("noise value out of range");

endmodule

bind value_noise_terrain_height_core vnth_checker u_vnth_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_height      (rsp_height),
   .rsp_noise_value (rsp_noise_value)
);

### verif/value_noise_terrain_height_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// value_noise_terrain_height_core_tb
// Drives column coordinates with random gaps and back pressure, predicts the
// smoothed value noise and clamped height of each beat, and checks every rsp
// beat in order against that prediction across several height limits.
// ----------------------------------------------------------------------------
module value_noise_terrain_height_core_tb;

   localparam int LATENCY     = 8;
   localparam int CYCLE_LIMIT = 400000;

   // predicted rsp beat
   typedef struct {
      logic [15:0]        height;
      logic signed [43:0] noise;
   } column_result_type;

   // expected column results, checked in arrival order
   class column_scoreboard;
      column_result_type pending[$];
      logic [15:0]    limit;
      int             errors;

      function new();
         limit  = vnth_pkg::LIMIT_RESET;
         errors = 0;
      endfunction

      // integer hash of one lattice point, Q1.30
      function longint lattice_noise(longint lx, longint lz);
         logic [31:0] n;
         logic [31:0] t;
         n = lx[31:0] + lz[31:0] * vnth_pkg::HASH_ROW_MUL;
         n = (n << 13) ^ n;
         t = (n * (n * n * vnth_pkg::HASH_SQ_MUL + vnth_pkg::HASH_SQ_ADD)
             + vnth_pkg::HASH_OFFSET) & {1'b0, vnth_pkg::HASH_MASK};
         return longint'(vnth_pkg::LATTICE_ONE) - longint'(t);
      endfunction

      // 3x3 weighted sum, scale 2^34
      function longint smoothed(longint lx, longint lz);
         longint c;
         longint s;
         c = lattice_noise(lx - 1, lz - 1) + lattice_noise(lx + 1, lz - 1)
           + lattice_noise(lx - 1, lz + 1) + lattice_noise(lx + 1, lz + 1);
         s = lattice_noise(lx - 1, lz) + lattice_noise(lx + 1, lz)
           + lattice_noise(lx, lz - 1) + lattice_noise(lx, lz + 1);
         return c + 2 * s + 4 * lattice_noise(lx, lz);
      endfunction

      // note one accepted req beat
      function void note_column(logic [15:0] cx, logic [15:0] cz);
         longint lx, lz, fx, fz, i1, i2, blend, scaled, h;
         column_result_type r;
         lx = cx >> vnth_pkg::CELL_LOG2;
         lz = cz >> vnth_pkg::CELL_LOG2;
         fx = cx[vnth_pkg::CELL_LOG2-1:0];
         fz = cz[vnth_pkg::CELL_LOG2-1:0];
         i1 = smoothed(lx, lz) * (16 - fx) + smoothed(lx + 1, lz) * fx;
         i2 = smoothed(lx, lz + 1) * (16 - fx) + smoothed(lx + 1, lz + 1) * fx;
         blend  = i1 * (16 - fz) + i2 * fz;
         scaled = 8 * (longint'(1) << vnth_pkg::BLEND_SHIFT) + 10 * blend;
         // truncate toward zero
         if (scaled >= 0) h = scaled >>> vnth_pkg::BLEND_SHIFT;
         else h = -((-scaled) >>> vnth_pkg::BLEND_SHIFT);
         if (h < 1) h = 1;
         if (h > longint'(limit)) h = limit;
         r.height = h[15:0];
         r.noise  = blend[43:0];
         pending.push_back(r);
      endfunction

      function void report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endfunction

      // check one rsp beat
      function void check_result(logic [15:0] height, logic signed [43:0] noise);
         column_result_type r;
         if (pending.size() == 0) begin
            report("unexpected rsp beat, height", height, 0);
            return;
         end
         r = pending.pop_front();
         if (height !== r.height) report("height", height, r.height);
         if (noise !== r.noise) report("noise_value", noise, r.noise);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_coord_x = 0;
   logic [15:0] req_coord_z = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_height;
   logic signed [43:0] rsp_noise_value;
   logic        csr_write_en = 0;
   logic [15:0] csr_write_data = 0;

   column_scoreboard board = new();
   int  cycles = 0;
   int  rsp_wait = 0;
   bit  no_gaps = 0;

   value_noise_terrain_height_core DUT (.*);

   always #2 clock = ~clock;

   // watchdog, checking and rsp wait count at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_height, rsp_noise_value);
         rsp_wait <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
      end
   end

   // rsp side: a drawn wait before each beat, stretches with none
   always @(negedge clock) begin
      if (reset || no_gaps) rsp_ready <= 1;
      else rsp_ready <= (rsp_wait == 0);
   end

   // send one req beat after a random gap
   task send_column(logic [15:0] cx, logic [15:0] cz);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (!no_gaps && $urandom_range(0, 3) != 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1;
      req_coord_x <= cx;
      req_coord_z <= cz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_column(cx, cz);
      @(negedge clock);
   endtask

   // let the pipe drain, then change the clamp
   task set_limit(logic [15:0] value);
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
      csr_write_en   <= 1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 0;
      board.limit = value;
   endtask

   // half near either end of the coordinate range, half across the full range
   function logic [15:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 63));
         1: return 16'(32'hffff - $urandom_range(0, 63));
         default: return 16'($urandom);
      endcase
   endfunction

   logic [15:0] limits[6] = '{16'd62, 16'd1, 16'd0, 16'hffff, 16'd10, 16'd17};

   initial begin
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, lattice edge, cell corners
      send_column(16'h0000, 16'h0000);
      send_column(16'hffff, 16'hffff);
      send_column(16'h0000, 16'hffff);
      send_column(16'hffff, 16'h0000);
      send_column(16'h000f, 16'h000f);
      send_column(16'h0010, 16'h0010);
      send_column(16'h8000, 16'h7fff);
      send_column(16'h5555, 16'haaaa);
      send_column(16'haaaa, 16'h5555);
      send_column(16'h0008, 16'hfff0);
      set_limit(16'd0);
      send_column(16'h0000, 16'h0000);
      send_column(16'h1234, 16'h4321);
      set_limit(16'hffff);
      send_column(16'h0000, 16'h0000);
      send_column(16'hffff, 16'hffff);
      send_column(16'h0f0f, 16'hf0f0);

      // random phases, each with its own clamp
      for (int p = 0; p < 6; p++) begin
         set_limit(limits[p]);
         no_gaps = (p == 3);
         for (int i = 0; i < 265; i++) send_column(pick_coord(), pick_coord());
      end
      no_gaps = 0;

      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
